// ===== sv/wsfd_pkg.sv =====
// wsfd_pkg: constants, result word type and helpers for the websocket frame decoder
// no dependencies; imported by websocket_frame_decoder_top

package wsfd_pkg;

  localparam logic [7:0] RSV_MASK = 8'h70;
  localparam logic [7:0] TOP_BIT = 8'h80;
  localparam logic [6:0] LEN_EXT16 = 7'h7e;
  localparam logic [6:0] LEN_EXT64 = 7'h7f;

  localparam logic [3:0] OP_TEXT = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING = 4'h9;
  localparam logic [3:0] OP_PONG = 4'ha;

  localparam logic [1:0] ST_TEXT = 2'd0;
  localparam logic [1:0] ST_CLOSE = 2'd1;
  localparam logic [1:0] ST_OTHER = 2'd2;
  localparam logic [1:0] ST_ERROR = 2'd3;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_RSV = 3'd1;
  localparam logic [2:0] ERR_FIN = 3'd2;
  localparam logic [2:0] ERR_UNMASKED = 3'd3;
  localparam logic [2:0] ERR_LEN64 = 3'd4;
  localparam logic [2:0] ERR_OPCODE = 3'd5;
  localparam logic [2:0] ERR_TRUNC = 3'd6;

  localparam int POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX = 17'h1ffff;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam int QDEPTH = 3;

  typedef struct packed {
    logic        kind;
    logic [7:0]  pbyte;
    logic [1:0]  status;
    logic [2:0]  cause;
    logic [3:0]  opcode;
    logic [15:0] length;
    logic        last;
  } result_t;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'(QDEPTH - 1)) ? 2'd0 : p + 2'd1;
  endfunction

endpackage

// ===== sv/websocket_frame_decoder_top.sv =====
// websocket_frame_decoder_top: client frame parser, unmasking and status reporting
// depends on wsfd_pkg; result words leave through a three-entry output queue
//
// channel  handshake            fields
// in       in_valid/in_ready    data_byte, frame_end
// out      out_valid/out_ready  item_kind, payload_byte, frame_status, error_cause,
//                               frame_opcode, payload_length, last_result
//
// one word per cycle while in_ready; header parse, unmask and status in the accept cycle
// results are registered into the queue on accept and show on out once at its head
// a frame end can cause two result words, the queue takes both in the same cycle
// in_ready is high while the queue holds at most one word, so a stalled out side blocks in
// synchronous reset clears the frame state and empties the queue

module websocket_frame_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        item_kind,
  output logic [7:0]  payload_byte,
  output logic [1:0]  frame_status,
  output logic [2:0]  error_cause,
  output logic [3:0]  frame_opcode,
  output logic [15:0] payload_length,
  output logic        last_result
);
  import wsfd_pkg::*;

  logic [POS_W-1:0] pos, pos_next;
  logic [7:0]       hdr, hdr_next;
  logic [15:0]      decl, decl_next;
  logic             ext, ext_next;
  logic [31:0]      key, key_next;
  logic [2:0]       ferr, ferr_next;

  result_t          q [QDEPTH];
  logic [1:0]       wr_ptr, rd_ptr, cnt;

  logic             accept, pop;
  logic [3:0]       op;
  logic             text, op_known, emit;
  logic [2:0]       err_a;
  logic [POS_W-1:0] hdr_len, key_end, need, off;
  logic [7:0]       kb;
  result_t          pay_item, stat_item, item0;
  logic [1:0]       push_n;

  assign accept = in_valid && in_ready;
  assign pop = out_valid && out_ready;
  assign in_ready = (cnt <= 2'd1);
  assign out_valid = (cnt != 2'd0);

  always_comb begin
    hdr_next = hdr;
    decl_next = decl;
    ext_next = ext;
    key_next = key;
    ferr_next = ferr;
    emit = 1'b0;
    kb = 8'd0;
    op_known = 1'b0;
    off = '0;

    // byte 0 checks
    if (pos == '0) begin
      hdr_next = data_byte;
      op_known = data_byte[3:0] inside {OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};
      if (ferr_next == ERR_NONE) begin
        if ((data_byte & RSV_MASK) != 8'd0) ferr_next = ERR_RSV;
        else if (!data_byte[7]) ferr_next = ERR_FIN;
        else if (!op_known) ferr_next = ERR_OPCODE;
      end
    end
    op = hdr_next[3:0];
    text = (op == OP_TEXT);
    err_a = ferr_next;

    hdr_len = ext ? 17'd4 : 17'd2;
    key_end = hdr_len + 17'd4;

    // length byte
    if (pos == 17'd1) begin
      if (ferr_next == ERR_NONE && !data_byte[7]) ferr_next = ERR_UNMASKED;
      if (text) begin
        if (data_byte[6:0] == LEN_EXT16) begin
          ext_next = 1'b1;
          decl_next = 16'd0;
        end else if (data_byte[6:0] == LEN_EXT64) begin
          if (ferr_next == ERR_NONE) ferr_next = ERR_LEN64;
        end else begin
          decl_next = {9'd0, data_byte[6:0]};
        end
      end
    end else if (pos >= 17'd2 && text && err_a == ERR_NONE) begin
      if (ext && pos == 17'd2) begin
        decl_next = {data_byte, 8'd0};
      end else if (ext && pos == 17'd3) begin
        decl_next = {decl[15:8], data_byte};
      end else if (decl != 16'd0 && pos >= hdr_len) begin
        if (pos < key_end) begin
          key_next = {key[23:0], data_byte};
        end else begin
          off = pos - key_end;
          if (off < {1'b0, decl}) begin
            emit = 1'b1;
            case (off[1:0])
              2'd0: kb = key[31:24];
              2'd1: kb = key[23:16];
              2'd2: kb = key[15:8];
              default: kb = key[7:0];
            endcase
          end
        end
      end
    end

    pos_next = (pos < POS_MAX) ? pos + 17'd1 : pos;

    // frame completion
    need = 17'd2;
    if (text) begin
      need = (ext_next ? 17'd4 : 17'd2) +
             ((decl_next != 16'd0) ? (17'd4 + {1'b0, decl_next}) : 17'd0);
    end
    if (frame_end && pos_next < need && ferr_next == ERR_NONE) ferr_next = ERR_TRUNC;

    pay_item.kind = KIND_PAYLOAD;
    pay_item.pbyte = data_byte ^ kb;
    pay_item.status = ST_TEXT;
    pay_item.cause = ERR_NONE;
    pay_item.opcode = op;
    pay_item.length = 16'd0;
    pay_item.last = !frame_end;

    stat_item.kind = KIND_STATUS;
    stat_item.pbyte = 8'd0;
    if (ferr_next != ERR_NONE) stat_item.status = ST_ERROR;
    else if (op == OP_CLOSE) stat_item.status = ST_CLOSE;
    else if (text) stat_item.status = ST_TEXT;
    else stat_item.status = ST_OTHER;
    stat_item.cause = ferr_next;
    stat_item.opcode = op;
    stat_item.length = text ? decl_next : 16'd0;
    stat_item.last = 1'b1;

    item0 = emit ? pay_item : stat_item;
    push_n = accept ? ({1'b0, emit} + {1'b0, frame_end}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      hdr <= 8'd0;
      decl <= 16'd0;
      ext <= 1'b0;
      key <= 32'd0;
      ferr <= ERR_NONE;
    end else if (accept) begin
      if (frame_end) begin
        pos <= '0;
        hdr <= 8'd0;
        decl <= 16'd0;
        ext <= 1'b0;
        key <= 32'd0;
        ferr <= ERR_NONE;
      end else begin
        pos <= pos_next;
        hdr <= hdr_next;
        decl <= decl_next;
        ext <= ext_next;
        key <= key_next;
        ferr <= ferr_next;
      end
    end
  end

  // output queue
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      if (push_n != 2'd0 && wr_ptr == 2'(i)) q[i] <= item0;
      if (push_n == 2'd2 && ptr_inc(wr_ptr) == 2'(i)) q[i] <= stat_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      cnt <= 2'd0;
    end else begin
      if (push_n == 2'd1) wr_ptr <= ptr_inc(wr_ptr);
      else if (push_n == 2'd2) wr_ptr <= ptr_inc(ptr_inc(wr_ptr));
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      cnt <= cnt + push_n - {1'b0, pop};
    end
  end

  assign item_kind = q[rd_ptr].kind;
  assign payload_byte = q[rd_ptr].pbyte;
  assign frame_status = q[rd_ptr].status;
  assign error_cause = q[rd_ptr].cause;
  assign frame_opcode = q[rd_ptr].opcode;
  assign payload_length = q[rd_ptr].length;
  assign last_result = q[rd_ptr].last;

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && frame_end |=> pos == '0 && ferr == ERR_NONE)
    else $error("frame state not cleared after frame end");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == KIND_STATUS |-> last_result)
    else $error("status word not marked last");

  a_err_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_kind == KIND_STATUS |->
      ((frame_status == ST_ERROR) == (error_cause != ERR_NONE)))
    else $error("status and error cause disagree");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= 2'(QDEPTH))
    else $error("output queue overflow");

endmodule
